/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every rising edge outside reset
`define RDC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// Check that cond never holds at a rising edge outside reset
`define RDC_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define RDC_ASSERT(lbl, clk, rst_n, prop)
`define RDC_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* src/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// Types, command codes, register indexes and reset values of the drive
// controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdc_pkg;

	localparam int TICKS_PER_US = 4;
	localparam int SAMPLE_BITS  = 12;

	// Remote command codes
	localparam logic [31:0] CMD_STOP      = 32'h19E6_0707;
	localparam logic [31:0] CMD_FORWARD   = 32'h9F60_0707;
	localparam logic [31:0] CMD_BACKWARD  = 32'h9E61_0707;
	localparam logic [31:0] CMD_FASTER    = 32'hF807_0707;
	localparam logic [31:0] CMD_SLOWER    = 32'hF40B_0707;
	localparam logic [31:0] CMD_LEFT      = 32'h9A65_0707;
	localparam logic [31:0] CMD_RIGHT     = 32'h9D62_0707;
	localparam logic [31:0] CMD_HOME_STOP = 32'h8679_0707;
	localparam logic [31:0] CMD_CENTER    = 32'h9768_0707;

	// Register indexes
	localparam logic [2:0] CFG_SENSOR_OFFSET = 3'd0;
	localparam logic [2:0] CFG_THRESHOLD     = 3'd1;
	localparam logic [2:0] CFG_INTERVAL      = 3'd2;
	localparam logic [2:0] CFG_PWM_PERIOD    = 3'd3;
	localparam logic [2:0] CFG_STEER_CENTER  = 3'd4;
	localparam logic [2:0] CFG_STEER_LEFT    = 3'd5;
	localparam logic [2:0] CFG_STEER_RIGHT   = 3'd6;
	localparam logic [2:0] CFG_STEER_STEP    = 3'd7;

	// Register reset values
	localparam logic [11:0] RST_SENSOR_OFFSET = 12'd0;
	localparam logic [11:0] RST_THRESHOLD     = 12'd1500;
	localparam logic [9:0]  RST_INTERVAL      = 10'd100;
	localparam logic [15:0] RST_PWM_PERIOD    = 16'd40000;
	localparam logic [11:0] RST_STEER_CENTER  = 12'd1470;
	localparam logic [11:0] RST_STEER_LEFT    = 12'd1770;
	localparam logic [11:0] RST_STEER_RIGHT   = 12'd1170;
	localparam logic [7:0]  RST_STEER_STEP    = 8'd15;

	// Divide a 16-bit value by ten: (x * 52429) >> 19 is exact below 2^16
	localparam logic [15:0] DIV10_MUL   = 16'd52429;
	localparam int          DIV10_SHIFT = 19;
	localparam logic [12:0] RST_DELTA   = 13'(RST_PWM_PERIOD / 10);

	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_FWD  = 2'd1,
		MODE_BACK = 2'd2
	} mode_t;

	// Work items carried from the front to the back
	typedef enum logic [3:0] {
		OP_NONE,
		OP_STOP,
		OP_FWD,
		OP_BACK,
		OP_FASTER,
		OP_SLOWER,
		OP_LEFT,
		OP_RIGHT,
		OP_HOME_STOP,
		OP_CENTER,
		OP_OBSTACLE
	} op_t;

	typedef struct packed {
		logic [11:0] sensor_offset;
		logic [11:0] obstacle_threshold;
		logic [9:0]  check_interval;
		logic [15:0] pwm_period;
		logic [11:0] steer_center;
		logic [11:0] steer_left_limit;
		logic [11:0] steer_right_limit;
		logic [7:0]  steer_step;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] period;
	} pwm_reload_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} qentry_t;

endpackage

/* src/rdc_front.sv */
// ----------------------------------------------------------------------------
// rdc_front
// Accepts input items, keeps the sensor mean and check phase, and turns every
// command and each sample that may see an obstacle into a back-end work entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic             action,
	input  logic [11:0]      sample,
	input  logic [31:0]      command_code,
	input  rdc_pkg::cfg_t    cfg,
	output rdc_pkg::qentry_t push
);

	logic               accept;
	logic [11:0]        raw;
	logic signed [12:0] x;
	logic signed [13:0] sum;
	logic signed [13:0] sum_adj;
	logic signed [12:0] mean_n;
	logic signed [12:0] mean_q;
	logic [9:0]         interval;
	logic [10:0]        phase_inc;
	logic [9:0]         phase_n;
	logic [9:0]         phase_q;
	logic               hit;
	rdc_pkg::op_t       cmd_op;

	assign accept = in_valid && !in_stall;

	// Remove the offset and average with the stored mean, rounding toward zero
	always_comb begin
		raw       = sample[rdc_pkg::SAMPLE_BITS-1:0];
		x         = $signed({1'b0, raw}) - $signed({1'b0, cfg.sensor_offset});
		sum       = {mean_q[12], mean_q} + {x[12], x};
		sum_adj   = sum + 14'({13'd0, sum[13]});
		mean_n    = sum_adj[13:1];
		interval  = (cfg.check_interval == 10'd0) ? 10'd1 : cfg.check_interval;
		phase_inc = {1'b0, phase_q} + 11'd1;
		phase_n   = (phase_inc >= {1'b0, interval}) ? 10'd0 : phase_inc[9:0];
		hit       = (phase_q == 10'd0) &&
			(mean_n >= $signed({1'b0, cfg.obstacle_threshold}));
	end

	// Classify the command code
	always_comb begin
		unique case (command_code)
			rdc_pkg::CMD_STOP:      cmd_op = rdc_pkg::OP_STOP;
			rdc_pkg::CMD_FORWARD:   cmd_op = rdc_pkg::OP_FWD;
			rdc_pkg::CMD_BACKWARD:  cmd_op = rdc_pkg::OP_BACK;
			rdc_pkg::CMD_FASTER:    cmd_op = rdc_pkg::OP_FASTER;
			rdc_pkg::CMD_SLOWER:    cmd_op = rdc_pkg::OP_SLOWER;
			rdc_pkg::CMD_LEFT:      cmd_op = rdc_pkg::OP_LEFT;
			rdc_pkg::CMD_RIGHT:     cmd_op = rdc_pkg::OP_RIGHT;
			rdc_pkg::CMD_HOME_STOP: cmd_op = rdc_pkg::OP_HOME_STOP;
			rdc_pkg::CMD_CENTER:    cmd_op = rdc_pkg::OP_CENTER;
			default:                cmd_op = rdc_pkg::OP_NONE;
		endcase
	end

	// Queue every command; queue a sample only when it may see an obstacle
	always_comb begin
		push.valid = accept && (action || hit);
		push.op    = action ? cmd_op : rdc_pkg::OP_OBSTACLE;
	end

	// Advance the mean and phase on each sample transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= '0;
			phase_q <= '0;
		end else if (accept && !action) begin
			mean_q  <= mean_n;
			phase_q <= phase_n;
		end
	end

endmodule

/* src/rdc_queue.sv */
// ----------------------------------------------------------------------------
// rdc_queue
// Two-entry queue of work entries between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  rdc_pkg::qentry_t push,
	input  logic             pop,
	output rdc_pkg::qentry_t head,
	output logic             full
);

	rdc_pkg::op_t mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.op    = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.op;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push.valid, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/rdc_back.sv */
// ----------------------------------------------------------------------------
// rdc_back
// Carries out queued work entries on the drive state and holds the result
// in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rdc_pkg::cfg_t        cfg,
	input  rdc_pkg::pwm_reload_t reload,
	input  rdc_pkg::qentry_t     head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [15:0]          forward_duty,
	output logic [15:0]          backward_duty,
	output logic [15:0]          servo_compare,
	output logic [1:0]           drive_mode,
	output logic                 burst,
	output logic                 last
);

	rdc_pkg::mode_t dir_q;
	rdc_pkg::mode_t dir_n;
	logic [15:0]    speed_q;
	logic [15:0]    speed_n;
	logic [11:0]    steer_q;
	logic [11:0]    steer_n;
	logic           pend_q;
	logic           pend_n;
	logic [12:0]    delta_q;
	logic [31:0]    prod;

	logic           out_free;
	logic           fire;
	logic           emit;
	logic [15:0]    res_fwd;
	logic [15:0]    res_back;
	rdc_pkg::mode_t res_mode;
	logic           res_burst;
	logic           res_last;
	logic [11:0]    res_steer;

	logic [12:0]    sum_l;
	logic [11:0]    steer_left;
	logic [12:0]    bound_r;
	logic [11:0]    steer_right;
	logic [16:0]    sum_s;
	logic [15:0]    speed_up;
	logic [15:0]    speed_dn;

	logic           out_valid_q;
	logic [15:0]    fwd_q;
	logic [15:0]    back_q;
	logic [15:0]    servo_q;
	rdc_pkg::mode_t mode_q;
	logic           burst_q;
	logic           last_q;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = head.valid && out_free;
	assign prod     = cfg.pwm_period * rdc_pkg::DIV10_MUL;

	// Clamp the steering and speed steps
	always_comb begin
		sum_l       = {1'b0, steer_q} + 13'({5'd0, cfg.steer_step});
		steer_left  = (sum_l > {1'b0, cfg.steer_left_limit}) ?
			cfg.steer_left_limit : sum_l[11:0];
		bound_r     = {1'b0, cfg.steer_right_limit} + 13'({5'd0, cfg.steer_step});
		steer_right = ({1'b0, steer_q} < bound_r) ?
			cfg.steer_right_limit : steer_q - 12'({4'd0, cfg.steer_step});
		sum_s       = {1'b0, speed_q} + 17'({4'd0, delta_q});
		speed_up    = (sum_s > {1'b0, cfg.pwm_period}) ? cfg.pwm_period : sum_s[15:0];
		speed_dn    = (speed_q < {3'd0, delta_q}) ? 16'd0 : speed_q - {3'd0, delta_q};
	end

	// Execute the head entry and form its result
	always_comb begin
		dir_n     = dir_q;
		speed_n   = speed_q;
		steer_n   = steer_q;
		pend_n    = pend_q;
		pop       = 1'b0;
		emit      = 1'b0;
		res_fwd   = 16'd0;
		res_back  = 16'd0;
		res_mode  = rdc_pkg::MODE_STOP;
		res_burst = 1'b0;
		res_last  = 1'b1;
		res_steer = steer_q;
		if (fire) begin
			if (pend_q) begin
				// Second result after a burst: reverse at speed, full left
				emit     = 1'b1;
				pop      = 1'b1;
				pend_n   = 1'b0;
				res_back = speed_q;
				res_mode = rdc_pkg::MODE_BACK;
			end else if (head.op == rdc_pkg::OP_OBSTACLE) begin
				if (dir_q == rdc_pkg::MODE_FWD) begin
					emit      = 1'b1;
					pend_n    = 1'b1;
					dir_n     = rdc_pkg::MODE_BACK;
					steer_n   = cfg.steer_left_limit;
					res_back  = cfg.pwm_period;
					res_mode  = rdc_pkg::MODE_BACK;
					res_burst = 1'b1;
					res_last  = 1'b0;
				end else begin
					pop = 1'b1;
				end
			end else begin
				emit = 1'b1;
				pop  = 1'b1;
				unique case (head.op)
					rdc_pkg::OP_STOP:      dir_n = rdc_pkg::MODE_STOP;
					rdc_pkg::OP_FWD:       dir_n = rdc_pkg::MODE_FWD;
					rdc_pkg::OP_BACK:      dir_n = rdc_pkg::MODE_BACK;
					rdc_pkg::OP_FASTER:    speed_n = speed_up;
					rdc_pkg::OP_SLOWER:    speed_n = speed_dn;
					rdc_pkg::OP_LEFT:      steer_n = steer_left;
					rdc_pkg::OP_RIGHT:     steer_n = steer_right;
					rdc_pkg::OP_HOME_STOP: begin
						steer_n = cfg.steer_center;
						dir_n   = rdc_pkg::MODE_STOP;
					end
					rdc_pkg::OP_CENTER:    steer_n = cfg.steer_center;
					default:               dir_n = dir_q;
				endcase
				res_steer = steer_n;
				unique case (dir_n)
					rdc_pkg::MODE_FWD: begin
						res_fwd  = speed_n;
						res_mode = rdc_pkg::MODE_FWD;
					end
					rdc_pkg::MODE_BACK: begin
						res_back = speed_n;
						res_mode = rdc_pkg::MODE_BACK;
					end
					default: res_mode = rdc_pkg::MODE_STOP;
				endcase
			end
		end
	end

	// Update drive state; a period write reloads speed to half
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= rdc_pkg::MODE_STOP;
			speed_q <= rdc_pkg::RST_PWM_PERIOD >> 1;
			steer_q <= rdc_pkg::RST_STEER_CENTER;
			pend_q  <= 1'b0;
			delta_q <= rdc_pkg::RST_DELTA;
		end else begin
			delta_q <= prod[rdc_pkg::DIV10_SHIFT+12:rdc_pkg::DIV10_SHIFT];
			if (reload.valid) begin
				speed_q <= reload.period >> 1;
			end else if (fire) begin
				speed_q <= speed_n;
			end
			if (fire) begin
				dir_q   <= dir_n;
				steer_q <= steer_n;
				pend_q  <= pend_n;
			end
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			fwd_q   <= res_fwd;
			back_q  <= res_back;
			servo_q <= 16'(32'(res_steer) * rdc_pkg::TICKS_PER_US);
			mode_q  <= res_mode;
			burst_q <= res_burst;
			last_q  <= res_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign forward_duty  = fwd_q;
	assign backward_duty = back_q;
	assign servo_compare = servo_q;
	assign drive_mode    = mode_q;
	assign burst         = burst_q;
	assign last          = last_q;

endmodule

/* src/remote_drive_controller.sv */
// ----------------------------------------------------------------------------
// remote_drive_controller
// Cart drive logic: sensor averaging with obstacle reversal and remote
// command handling, front end and back end joined by a short queue.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): action 0 carries a sensor sample,
// action 1 a remote command code. A transfer happens when in_valid is high
// and in_stall low. Output channel (out_valid / out_stall) carries one
// result per transfer; last marks the final result of an input item.
// Every command yields one result; a sample yields none, or two (a burst
// result, then the full-left reverse) when it detects an obstacle while
// driving forward. Configuration writes go through cfg_valid / cfg_ready
// (always ready) with cfg_index and cfg_data; the user must make them only
// while the block is idle, as the block itself does not enforce this.
// A result passes through the queue and then the output register.
// Throughput: one item per cycle while out_stall is low; an obstacle
// reversal makes the back end give two results for one queue entry.
// in_stall rises only when the two-entry queue is full, as it can be
// during an obstacle reversal and while out_stall holds the back end.
// Reset loads the register defaults, stops the drive, centers steering and
// sets speed to half the period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module remote_drive_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [11:0] sample,
	input  logic [31:0] command_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] forward_duty,
	output logic [15:0] backward_duty,
	output logic [15:0] servo_compare,
	output logic [1:0]  drive_mode,
	output logic        burst,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	rdc_pkg::cfg_t        cfg_q;
	rdc_pkg::pwm_reload_t reload;
	rdc_pkg::qentry_t     push;
	rdc_pkg::qentry_t     head;
	logic                 pop;
	logic                 q_full;
	logic                 cfg_write;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign in_stall  = q_full;

	// Signal a speed reload on a period write
	always_comb begin
		reload.valid  = cfg_write && (cfg_index == rdc_pkg::CFG_PWM_PERIOD);
		reload.period = cfg_data;
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_offset      <= rdc_pkg::RST_SENSOR_OFFSET;
			cfg_q.obstacle_threshold <= rdc_pkg::RST_THRESHOLD;
			cfg_q.check_interval     <= rdc_pkg::RST_INTERVAL;
			cfg_q.pwm_period         <= rdc_pkg::RST_PWM_PERIOD;
			cfg_q.steer_center       <= rdc_pkg::RST_STEER_CENTER;
			cfg_q.steer_left_limit   <= rdc_pkg::RST_STEER_LEFT;
			cfg_q.steer_right_limit  <= rdc_pkg::RST_STEER_RIGHT;
			cfg_q.steer_step         <= rdc_pkg::RST_STEER_STEP;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rdc_pkg::CFG_SENSOR_OFFSET: cfg_q.sensor_offset      <= cfg_data[11:0];
				rdc_pkg::CFG_THRESHOLD:     cfg_q.obstacle_threshold <= cfg_data[11:0];
				rdc_pkg::CFG_INTERVAL:      cfg_q.check_interval     <= cfg_data[9:0];
				rdc_pkg::CFG_PWM_PERIOD:    cfg_q.pwm_period         <= cfg_data;
				rdc_pkg::CFG_STEER_CENTER:  cfg_q.steer_center       <= cfg_data[11:0];
				rdc_pkg::CFG_STEER_LEFT:    cfg_q.steer_left_limit   <= cfg_data[11:0];
				rdc_pkg::CFG_STEER_RIGHT:   cfg_q.steer_right_limit  <= cfg_data[11:0];
				rdc_pkg::CFG_STEER_STEP:    cfg_q.steer_step         <= cfg_data[7:0];
				default:                    cfg_q <= cfg_q;
			endcase
		end
	end

	rdc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.sample       (sample),
		.command_code (command_code),
		.cfg          (cfg_q),
		.push         (push)
	);

	rdc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (q_full)
	);

	rdc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.reload        (reload),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.forward_duty  (forward_duty),
		.backward_duty (backward_duty),
		.servo_compare (servo_compare),
		.drive_mode    (drive_mode),
		.burst         (burst),
		.last          (last)
	);

	// A push never lands on a full queue
	`RDC_NEVER(a_queue_no_overflow, clk, arst_n, push.valid && q_full)
	// A burst transfer is followed at once by the closing reverse result
	`RDC_ASSERT(a_burst_pair, clk, arst_n, (out_valid && !out_stall && burst) |=> (out_valid && !burst && last && (drive_mode == rdc_pkg::MODE_BACK)))
	// A burst result is never the last one of its item
	`RDC_ASSERT(a_burst_not_last, clk, arst_n, (out_valid && burst) |-> !last)
	// Both motor channels are never driven together
	`RDC_ASSERT(a_one_motor, clk, arst_n, out_valid |-> ((forward_duty == 16'd0) || (backward_duty == 16'd0)))

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cart drive controller. A behavioral model of
// the averaging, obstacle reversal and remote commands predicts every
// result; the checker compares each output transfer in order. Directed
// tests cover each command and the interval and steering corner cases.
// Random phases follow, with registers reprogrammed between phases and
// random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic [15:0]    fwd;
		logic [15:0]    back;
		logic [15:0]    servo;
		rdc_pkg::mode_t mode;
		logic           burst;
		logic           last;
	} duty_result_t;

	localparam logic [31:0] KNOWN_CODES [9] = '{rdc_pkg::CMD_STOP, rdc_pkg::CMD_FORWARD,
		rdc_pkg::CMD_BACKWARD, rdc_pkg::CMD_FASTER, rdc_pkg::CMD_SLOWER, rdc_pkg::CMD_LEFT,
		rdc_pkg::CMD_RIGHT, rdc_pkg::CMD_HOME_STOP, rdc_pkg::CMD_CENTER};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = 1'b0;
	logic [11:0] sample = '0;
	logic [31:0] command_code = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] forward_duty;
	logic [15:0] backward_duty;
	logic [15:0] servo_compare;
	logic [1:0]  drive_mode;
	logic        burst;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Model state
	rdc_pkg::cfg_t  cfg_model;
	int             mean_level;
	int             phase_count;
	rdc_pkg::mode_t heading;
	int             speed_now;
	int             steer_pos;

	duty_result_t expected_duties[$];

	int mismatch_count = 0;
	int cycle_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_request_cycles = 0;
	int hold_request_seq = 0;
	int hold_seen_seq = 0;

	remote_drive_controller dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.sample       (sample),
		.command_code (command_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.forward_duty (forward_duty),
		.backward_duty(backward_duty),
		.servo_compare(servo_compare),
		.drive_mode   (drive_mode),
		.burst        (burst),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short idle stretches, now and then a long one
	function automatic int idle_length();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	// Pick a register value, favoring the ends of its range
	function automatic int pick_value(int lo, int hi);
		int r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return $urandom_range(lo, hi);
	endfunction

	function automatic duty_result_t make_duty(int fwd, int back, rdc_pkg::mode_t mode,
		logic bst, logic fin);
		duty_result_t d;
		d.fwd = 16'(fwd);
		d.back = 16'(back);
		d.servo = 16'(steer_pos * rdc_pkg::TICKS_PER_US);
		d.mode = mode;
		d.burst = bst;
		d.last = fin;
		return d;
	endfunction

	function automatic void reset_drive_model();
		cfg_model.sensor_offset = rdc_pkg::RST_SENSOR_OFFSET;
		cfg_model.obstacle_threshold = rdc_pkg::RST_THRESHOLD;
		cfg_model.check_interval = rdc_pkg::RST_INTERVAL;
		cfg_model.pwm_period = rdc_pkg::RST_PWM_PERIOD;
		cfg_model.steer_center = rdc_pkg::RST_STEER_CENTER;
		cfg_model.steer_left_limit = rdc_pkg::RST_STEER_LEFT;
		cfg_model.steer_right_limit = rdc_pkg::RST_STEER_RIGHT;
		cfg_model.steer_step = rdc_pkg::RST_STEER_STEP;
		mean_level = 0;
		phase_count = 0;
		heading = rdc_pkg::MODE_STOP;
		speed_now = int'(rdc_pkg::RST_PWM_PERIOD) / 2;
		steer_pos = int'(rdc_pkg::RST_STEER_CENTER);
	endfunction

	function automatic void apply_register(logic [2:0] idx, logic [15:0] data);
		case (idx)
			rdc_pkg::CFG_SENSOR_OFFSET: cfg_model.sensor_offset = data[11:0];
			rdc_pkg::CFG_THRESHOLD:     cfg_model.obstacle_threshold = data[11:0];
			rdc_pkg::CFG_INTERVAL:      cfg_model.check_interval = data[9:0];
			rdc_pkg::CFG_PWM_PERIOD: begin
				cfg_model.pwm_period = data;
				speed_now = int'(data) / 2;
			end
			rdc_pkg::CFG_STEER_CENTER:  cfg_model.steer_center = data[11:0];
			rdc_pkg::CFG_STEER_LEFT:    cfg_model.steer_left_limit = data[11:0];
			rdc_pkg::CFG_STEER_RIGHT:   cfg_model.steer_right_limit = data[11:0];
			rdc_pkg::CFG_STEER_STEP:    cfg_model.steer_step = data[7:0];
			default: ;
		endcase
	endfunction

	// Advance the drive model by one accepted item and queue its results
	function automatic void predict_drive_results(logic act, logic [11:0] smp,
		logic [31:0] code);
		int x;
		int interval;
		int period;
		int delta;
		int s;
		bit check;
		period = int'(cfg_model.pwm_period);
		if (!act) begin
			x = int'(smp) - int'(cfg_model.sensor_offset);
			interval = (cfg_model.check_interval == 0) ? 1 : int'(cfg_model.check_interval);
			check = (phase_count == 0);
			mean_level = (mean_level + x) / 2;
			phase_count = (phase_count + 1 >= interval) ? 0 : phase_count + 1;
			if (check && mean_level >= int'(cfg_model.obstacle_threshold) &&
			    heading == rdc_pkg::MODE_FWD) begin
				heading = rdc_pkg::MODE_BACK;
				expected_duties.push_back(make_duty(0, period, rdc_pkg::MODE_BACK,
					1'b1, 1'b0));
				steer_pos = int'(cfg_model.steer_left_limit);
				expected_duties.push_back(make_duty(0, speed_now, rdc_pkg::MODE_BACK,
					1'b0, 1'b1));
			end
			return;
		end
		delta = period / 10;
		case (code)
			rdc_pkg::CMD_STOP:     heading = rdc_pkg::MODE_STOP;
			rdc_pkg::CMD_FORWARD:  heading = rdc_pkg::MODE_FWD;
			rdc_pkg::CMD_BACKWARD: heading = rdc_pkg::MODE_BACK;
			rdc_pkg::CMD_FASTER:
				speed_now = (speed_now + delta > period) ? period : speed_now + delta;
			rdc_pkg::CMD_SLOWER:
				speed_now = (speed_now < delta) ? 0 : speed_now - delta;
			rdc_pkg::CMD_LEFT: begin
				s = steer_pos + int'(cfg_model.steer_step);
				steer_pos = (s > int'(cfg_model.steer_left_limit)) ?
					int'(cfg_model.steer_left_limit) : s;
			end
			rdc_pkg::CMD_RIGHT: begin
				s = steer_pos - int'(cfg_model.steer_step);
				steer_pos = (s < int'(cfg_model.steer_right_limit)) ?
					int'(cfg_model.steer_right_limit) : s;
			end
			rdc_pkg::CMD_HOME_STOP: begin
				steer_pos = int'(cfg_model.steer_center);
				heading = rdc_pkg::MODE_STOP;
			end
			rdc_pkg::CMD_CENTER:   steer_pos = int'(cfg_model.steer_center);
			default: ;
		endcase
		case (heading)
			rdc_pkg::MODE_FWD:
				expected_duties.push_back(make_duty(speed_now, 0, rdc_pkg::MODE_FWD,
					1'b0, 1'b1));
			rdc_pkg::MODE_BACK:
				expected_duties.push_back(make_duty(0, speed_now, rdc_pkg::MODE_BACK,
					1'b0, 1'b1));
			default:
				expected_duties.push_back(make_duty(0, 0, rdc_pkg::MODE_STOP, 1'b0, 1'b1));
		endcase
	endfunction

	// Offer one item, hold it until the transfer, then predict
	task automatic send_item(logic act, logic [11:0] smp, logic [31:0] code);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat (idle_length()) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		sample <= smp;
		command_code <= code;
		do
			@(posedge clk);
		while (in_stall);
		predict_drive_results(act, smp, code);
	endtask

	task automatic send_sample(logic [11:0] smp);
		send_item(1'b0, smp, $urandom);
	endtask

	task automatic send_command(logic [31:0] code);
		send_item(1'b1, 12'($urandom), code);
	endtask

	// Drop valid and let every queued and silent item drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_duties.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_register(idx, 16'(value));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Check each output transfer against the oldest prediction
	always @(posedge clk) begin
		duty_result_t got;
		duty_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{forward_duty, backward_duty, servo_compare,
				rdc_pkg::mode_t'(drive_mode), burst, last};
			if (expected_duties.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: fwd=%0d back=%0d servo=%0d mode=%0d burst=%0b last=%0b",
						got.fwd, got.back, got.servo, got.mode, got.burst, got.last);
			end else begin
				want = expected_duties.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"duty mismatch: expected fwd=%0d back=%0d servo=%0d mode=%0d ",
							"burst=%0b last=%0b, got fwd=%0d back=%0d servo=%0d mode=%0d ",
							"burst=%0b last=%0b"},
							want.fwd, want.back, want.servo, want.mode, want.burst, want.last,
							got.fwd, got.back, got.servo, got.mode, got.burst, got.last);
				end
			end
		end
	end

	// Drive output stall: long hold-off on request, else random stalls
	always @(posedge clk) begin
		if (hold_request_seq != hold_seen_seq) begin
			hold_seen_seq = hold_request_seq;
			hold_left = hold_request_cycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left = idle_length() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Every known command once, plus unknown codes at both ends
	task automatic test_command_set();
		send_command(32'h0000_0000);
		send_command(32'hFFFF_FFFF);
		foreach (KNOWN_CODES[i])
			send_command(KNOWN_CODES[i]);
	endtask

	// Reverse on an obstacle while going forward; no result when quiet
	task automatic test_obstacle_reversal();
		send_command(rdc_pkg::CMD_FORWARD);
		send_sample(12'd4095);
		send_sample(12'd0);
	endtask

	// Zero interval tests every sample; lowering the interval wraps the phase
	task automatic test_check_interval();
		wait_idle();
		cfg_write(rdc_pkg::CFG_INTERVAL, 0);
		send_command(rdc_pkg::CMD_FORWARD);
		send_sample(12'd4095);
		send_sample(12'd4095);
		wait_idle();
		cfg_write(rdc_pkg::CFG_INTERVAL, int'(rdc_pkg::RST_INTERVAL));
		repeat (3) send_sample(12'd100);
		wait_idle();
		cfg_write(rdc_pkg::CFG_INTERVAL, 2);
		send_command(rdc_pkg::CMD_FORWARD);
		send_sample(12'd4095);
		send_sample(12'd4095);
	endtask

	// Inverted limits, and a center write that only takes effect on centering
	task automatic test_steering_limits();
		wait_idle();
		cfg_write(rdc_pkg::CFG_STEER_LEFT, 500);
		cfg_write(rdc_pkg::CFG_STEER_RIGHT, 2500);
		send_command(rdc_pkg::CMD_LEFT);
		send_command(rdc_pkg::CMD_RIGHT);
		wait_idle();
		cfg_write(rdc_pkg::CFG_STEER_CENTER, 2500);
		send_command(rdc_pkg::CMD_LEFT);
		send_command(rdc_pkg::CMD_CENTER);
	endtask

	// Hold the output off long enough to fill the block and stall its input
	task automatic test_backpressure();
		wait_idle();
		gap_pct = 0;
		stall_pct = 0;
		hold_request_cycles = 300;
		hold_request_seq++;
		repeat (60) begin
			if ($urandom_range(0, 2) == 0)
				send_sample(12'($urandom));
			else
				send_command(KNOWN_CODES[$urandom_range(0, 8)]);
		end
	endtask

	// One random phase: reprogram, then drive approach sequences and noise
	task automatic test_random_drive(int phase);
		int count;
		int r;
		int k;
		wait_idle();
		if (phase == 0) begin
			cfg_write(rdc_pkg::CFG_SENSOR_OFFSET, 0);
			cfg_write(rdc_pkg::CFG_THRESHOLD, 0);
			cfg_write(rdc_pkg::CFG_INTERVAL, 1);
			cfg_write(rdc_pkg::CFG_PWM_PERIOD, 10);
			cfg_write(rdc_pkg::CFG_STEER_CENTER, 500);
			cfg_write(rdc_pkg::CFG_STEER_LEFT, 500);
			cfg_write(rdc_pkg::CFG_STEER_RIGHT, 500);
			cfg_write(rdc_pkg::CFG_STEER_STEP, 1);
		end else if (phase == 1) begin
			cfg_write(rdc_pkg::CFG_SENSOR_OFFSET, 4095);
			cfg_write(rdc_pkg::CFG_THRESHOLD, 4095);
			cfg_write(rdc_pkg::CFG_INTERVAL, 1023);
			cfg_write(rdc_pkg::CFG_PWM_PERIOD, 65535);
			cfg_write(rdc_pkg::CFG_STEER_CENTER, 2500);
			cfg_write(rdc_pkg::CFG_STEER_LEFT, 2500);
			cfg_write(rdc_pkg::CFG_STEER_RIGHT, 2500);
			cfg_write(rdc_pkg::CFG_STEER_STEP, 255);
		end else begin
			cfg_write(rdc_pkg::CFG_SENSOR_OFFSET,
				($urandom_range(0, 4) == 0) ? pick_value(0, 4095) : $urandom_range(0, 400));
			cfg_write(rdc_pkg::CFG_THRESHOLD,
				($urandom_range(0, 4) == 0) ? pick_value(0, 4095) : $urandom_range(0, 2500));
			cfg_write(rdc_pkg::CFG_INTERVAL,
				($urandom_range(0, 4) == 0) ? pick_value(1, 1023) : $urandom_range(1, 6));
			cfg_write(rdc_pkg::CFG_PWM_PERIOD, pick_value(10, 65535));
			cfg_write(rdc_pkg::CFG_STEER_CENTER, pick_value(500, 2500));
			cfg_write(rdc_pkg::CFG_STEER_LEFT, pick_value(500, 2500));
			cfg_write(rdc_pkg::CFG_STEER_RIGHT, pick_value(500, 2500));
			cfg_write(rdc_pkg::CFG_STEER_STEP, pick_value(1, 255));
		end
		// Leave every fourth phase free of idling
		if (phase % 4 == 3) begin
			gap_pct = 0;
			stall_pct = 0;
		end else begin
			gap_pct = $urandom_range(10, 50);
			stall_pct = $urandom_range(10, 50);
		end
		count = 0;
		while (count < PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				// Drive forward into a run of mostly high readings
				send_command(rdc_pkg::CMD_FORWARD);
				count++;
				k = $urandom_range(1, 12);
				repeat (k) begin
					if ($urandom_range(0, 99) < 15)
						send_command(KNOWN_CODES[$urandom_range(0, 8)]);
					else if ($urandom_range(0, 9) < 7)
						send_sample(12'($urandom_range(2048, 4095)));
					else
						send_sample(12'($urandom));
					count++;
				end
			end else if (r < 85) begin
				send_command(KNOWN_CODES[$urandom_range(0, 8)]);
				count++;
			end else if (r < 93) begin
				send_command($urandom);
				count++;
			end else begin
				send_sample(12'($urandom));
				count++;
			end
		end
	endtask

	initial begin
		reset_drive_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_command_set();
		test_obstacle_reversal();
		test_check_interval();
		test_steering_limits();
		for (int p = 0; p < 8; p++)
			test_random_drive(p);
		test_backpressure();

		wait_idle();
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
